FILE: hw/rtl/dhcp_opt_pkg.sv
package dhcp_opt_pkg;

  localparam int unsigned MAX_OPTION_BYTES = 312;

  localparam logic [7:0] END_CODE      = 8'd255;
  localparam logic [7:0] TEXT_HOSTNAME = 8'd12;
  localparam logic [7:0] TEXT_DOMAIN   = 8'd15;
  localparam logic [8:0] COOKIE_LAST   = 9'd3;
  localparam logic [8:0] POS_MAX       = 9'd511;

  localparam logic [1:0] CFG_WANTED_CODE = 2'd0;
  localparam logic [1:0] CFG_BUFFER_SIZE = 2'd1;

  localparam logic [7:0] WANTED_RESET = 8'd0;
  localparam logic [7:0] BUFSIZE_RESET = 8'd4;

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_FOUND     = 3'd1,
    K_SIZE_ERR  = 3'd2,
    K_END       = 3'd3,
    K_NOT_FOUND = 3'd4,
    K_TRUNC     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_COOKIE   = 3'd0,
    PH_CODE     = 3'd1,
    PH_LEN_MISS = 3'd2,
    PH_LEN_HIT  = 3'd3,
    PH_COPY     = 3'd4,
    PH_SKIP     = 3'd5
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_GCD  = 1'b1
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [8:0] value;
    logic       last_result;
  } res_t;

endpackage

FILE: hw/rtl/dhcp_option_extract.sv
// dhcp option extractor
// in_*  : one byte of a dhcp options area per word, in_tlast on the final byte of the area.
//         the first four bytes (magic cookie) are skipped, then code/length pairs are walked.
// out_* : result words; out_tuser gives the kind, out_tlast marks the final result of an area.
//         a match gives a found or truncated word with the copy count, followed by the copied
//         data bytes; other answers are size error, end offset or not found.
// cfg_* : register writes, index 0 wanted code, index 1 buffer size; always ready.
// timing: a result is written to the queue as the byte that causes it is taken; for the
//   length byte of a matching option, it is written as the gcd below finishes.
// throughput: one byte per cycle while two queue words are free, except on the length byte
//   of a matching option, where a shared subtract unit works out gcd(buffer size, length)
//   one step per cycle; that byte holds the input until the subtractive euclid steps end.
// results go through a four-word queue; a byte is taken only while two words are free, so a
//   stalled receiver holds the input once the queue fills and nothing is lost.
// reset (rst_n low, synchronous) empties the queue, restores the registers to wanted code 0
//   and buffer size 4 and returns the walk to the cookie; the same walk state is restored
//   after every byte marked last.
module dhcp_option_extract
  import dhcp_opt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] option_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [16:8] value, [23:17] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] wanted_r, bufsize_r;

  state_t     state_r, state_nxt;
  logic [8:0] pos_r, pos_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] copy_r, copy_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic       done_r, done_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic [7:0] ga_r, gb_r;

  res_t       fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  logic       in_acc, pop, need_gcd, ev_fire;
  logic       gcd_load, gcd_step, gcd_done, gcd_gt1;
  logic [7:0] gcd_diff;
  logic [7:0] ev_byte;
  logic       ev_last;
  res_t       p_res, nf_res, r0, r1;
  logic       p_v, tail_v;
  logic [1:0] npush;
  logic [9:0] skip_end;
  logic       is_text;
  logic [8:0] pos_inc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;
  assign need_gcd  = !done_r && (phase_r == PH_LEN_HIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r  <= WANTED_RESET;
      bufsize_r <= BUFSIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WANTED_CODE: wanted_r  <= cfg_data;
        CFG_BUFFER_SIZE: bufsize_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared subtract unit for the gcd
  assign gcd_done = (ga_r == gb_r) || (ga_r == 8'd0) || (gb_r == 8'd0);
  assign gcd_diff = (ga_r > gb_r) ? (ga_r - gb_r) : (gb_r - ga_r);
  assign gcd_gt1  = (ga_r == gb_r) ? (ga_r > 8'd1) : ((ga_r | gb_r) > 8'd1);

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && need_gcd) state_nxt = ST_GCD;
      ST_GCD:  if (gcd_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    gcd_load  = 1'b0;
    gcd_step  = 1'b0;
    ev_fire   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = (cnt_r <= 3'd2);
        gcd_load  = in_acc && need_gcd;
        ev_fire   = in_acc && !need_gcd;
      end
      ST_GCD: begin
        gcd_step = !gcd_done;
        ev_fire  = gcd_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (gcd_load) begin
      ga_r <= bufsize_r;
      gb_r <= in_tdata;
    end else if (gcd_step) begin
      if (ga_r > gb_r) begin
        ga_r <= gcd_diff;
      end else begin
        gb_r <= gcd_diff;
      end
    end
  end

  assign ev_byte  = (state_r == ST_GCD) ? byte_r : in_tdata;
  assign ev_last  = (state_r == ST_GCD) ? last_r : in_tlast;
  assign skip_end = {1'b0, pos_r} + {2'b00, ev_byte} + 10'd1;
  assign is_text  = (wanted_r == TEXT_HOSTNAME) || (wanted_r == TEXT_DOMAIN);
  assign pos_inc  = (pos_r < POS_MAX) ? (pos_r + 9'd1) : POS_MAX;

  always_comb begin
    nf_res = '{kind: K_NOT_FOUND, data_byte: 8'd0, value: 9'd0, last_result: 1'b1};
  end

  // walk one byte
  always_comb begin
    p_v       = 1'b0;
    p_res     = nf_res;
    phase_nxt = phase_r;
    copy_nxt  = copy_r;
    skip_nxt  = skip_r;
    if (!done_r) begin
      case (phase_r)
        PH_COOKIE: if (pos_r >= COOKIE_LAST) phase_nxt = PH_CODE;
        PH_CODE: begin
          if (pos_r >= 9'(MAX_OPTION_BYTES)) begin
            p_v = 1'b1;
          end else if (ev_byte == END_CODE) begin
            p_v = 1'b1;
            if (wanted_r == END_CODE) begin
              p_res.kind  = K_END;
              p_res.value = pos_r;
            end
          end else begin
            phase_nxt = (ev_byte == wanted_r) ? PH_LEN_HIT : PH_LEN_MISS;
          end
        end
        PH_LEN_MISS: begin
          if (skip_end >= 10'(MAX_OPTION_BYTES)) begin
            p_v = 1'b1;
          end else begin
            skip_nxt  = ev_byte;
            phase_nxt = (ev_byte != 8'd0) ? PH_SKIP : PH_CODE;
          end
        end
        PH_LEN_HIT: begin
          p_v        = 1'b1;
          p_res.kind = K_SIZE_ERR;
          if (bufsize_r != 8'd0) begin
            if (bufsize_r >= ev_byte && (gcd_gt1 || is_text || ev_byte == 8'd1)) begin
              p_res.kind  = K_FOUND;
              p_res.value = {1'b0, ev_byte};
            end else if (bufsize_r < ev_byte && (gcd_gt1 || is_text)) begin
              p_res.kind  = K_TRUNC;
              p_res.value = {1'b0, bufsize_r};
            end
          end
          if (p_res.kind != K_SIZE_ERR) begin
            p_res.last_result = (p_res.value == 9'd0);
            copy_nxt          = p_res.value[7:0];
            phase_nxt         = PH_COPY;
          end
        end
        PH_COPY: begin
          if (copy_r != 8'd0) copy_nxt = copy_r - 8'd1;
          p_v               = 1'b1;
          p_res.kind        = K_DATA;
          p_res.data_byte   = ev_byte;
          p_res.last_result = (copy_nxt == 8'd0);
        end
        PH_SKIP: begin
          if (skip_r != 8'd0) skip_nxt = skip_r - 8'd1;
          if (skip_nxt == 8'd0) phase_nxt = PH_CODE;
        end
        default: phase_nxt = PH_CODE;
      endcase
    end
    // area ended before any final word
    tail_v   = ev_last && !done_r && !(p_v && p_res.last_result);
    done_nxt = done_r || (p_v && p_res.last_result) || tail_v;
    pos_nxt  = pos_inc;
    if (ev_last) begin
      pos_nxt   = 9'd0;
      phase_nxt = PH_COOKIE;
      copy_nxt  = 8'd0;
      skip_nxt  = 8'd0;
      done_nxt  = 1'b0;
    end
    r0    = p_v ? p_res : nf_res;
    r1    = nf_res;
    npush = 2'({1'b0, p_v} + {1'b0, tail_v});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 9'd0;
      phase_r <= PH_COOKIE;
      copy_r  <= 8'd0;
      skip_r  <= 8'd0;
      done_r  <= 1'b0;
    end else if (ev_fire) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      copy_r  <= copy_nxt;
      skip_r  <= skip_nxt;
      done_r  <= done_nxt;
    end
  end

  // result queue, up to two words pushed per byte
  always_ff @(posedge clk) begin
    if (ev_fire && npush != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
      if (npush == 2'd2) fifo_r[wr_ptr_r + 2'd1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (ev_fire) wr_ptr_r <= wr_ptr_r + npush;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + (ev_fire ? {1'b0, npush} : 3'd0) - {2'b00, pop};
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {7'd0, fifo_r[rd_ptr_r].value, fifo_r[rd_ptr_r].data_byte};
  assign out_tuser  = fifo_r[rd_ptr_r].kind;
  assign out_tlast  = fifo_r[rd_ptr_r].last_result;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_gcd_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD) |-> !in_tready)
    else $error("byte taken while gcd runs");

  a_gcd_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD && !gcd_done) |=>
      ({1'b0, ga_r} + {1'b0, gb_r}) < ({1'b0, $past(ga_r)} + {1'b0, $past(gb_r)}))
    else $error("gcd step made no progress");

  a_gcd_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD) |-> (phase_r == PH_LEN_HIT && !done_r))
    else $error("gcd running outside a matching length byte");

endmodule
